// ----- rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/fpt_pkg.sv -----
package fpt_pkg;

  localparam int NumTreesDef = 10;
  localparam int CodeBitsDef = 13;

  localparam int FernCodeW = 13;
  localparam int CountW    = 16;
  localparam int SumW      = 17;
  localparam int DvdW      = 32;
  localparam int DsrW      = 21;

  localparam logic [SumW-1:0]   Half     = 17'd32768;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  typedef struct packed {
    logic                 action;
    logic [FernCodeW-1:0] fern_code;
    logic                 label_positive;
  } in_t;

  typedef struct packed {
    logic [15:0] confidence;
    logic        passed;
    logic        updated;
  } out_t;

  // One table entry: posterior and both counts.
  typedef struct packed {
    logic [CountW-1:0] post;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] neg;
  } entry_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- rtl/fpt_ram.sv -----
module fpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/fpt_div.sv -----
// Restoring divider, one quotient bit per cycle.
module fpt_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpt_pkg::div_ctl_t        ctl_i,
  input  logic [fpt_pkg::DvdW-1:0] dividend_i,
  input  logic [fpt_pkg::DsrW-1:0] divisor_i,
  output fpt_pkg::div_sts_t        sts_o,
  output logic [fpt_pkg::DvdW-1:0] quotient_o
);

  localparam int CntW = $clog2(fpt_pkg::DvdW);
  localparam int RemW = fpt_pkg::DsrW + 1;

  logic [fpt_pkg::DvdW-1:0] dvd_q, dvd_d;
  logic [fpt_pkg::DsrW-1:0] dsr_q;
  logic [RemW-1:0]          rem_q, rem_d, rem_sh;
  logic [RemW:0]            diff;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;

  always_comb begin
    rem_sh = {rem_q[RemW-2:0], dvd_q[fpt_pkg::DvdW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
    if (!diff[RemW]) begin
      rem_d = diff[RemW-1:0];
      dvd_d = {dvd_q[fpt_pkg::DvdW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      dvd_d = {dvd_q[fpt_pkg::DvdW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(fpt_pkg::DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start && !busy_q) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- rtl/fern_posterior_table_top.sv -----
// Random-ferns posterior table.
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat per tree, trees in
// order, NumTrees beats make one window. Output channel (out_valid_o/out_ready_i,
// out_data_o): one beat per window with the summed confidence, pass flag and
// update flag. cfg_we_i/cfg_wdata_i writes classifier_enabled (reset 1).
// Table: one synchronous RAM of NumTrees << CodeBits entries, each holding the
// posterior and both counts, addressed by {tree, code}.
// Throughput: within a window one beat per cycle (RAM read, then accumulate);
// after the window's last beat the input holds through the final accumulate
// and the decision before the next beat is taken.
// The result passes the read and decision stages into the output register.
// Learning: when the result says updated, the block walks all trees, each
// read, count bump, divide, write back; no input is taken during the walk.
// Reset: a clearing pass writes every RAM entry to zero, one per cycle;
// in_ready_o stays low during the pass.
// Output stall: the result sits in an output register; the block keeps taking
// beats of the next window and holds only at its decision cycle.
`include "assert_macros.svh"

module fern_posterior_table_top #(
  parameter int NumTrees = fpt_pkg::NumTreesDef,
  parameter int CodeBits = fpt_pkg::CodeBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpt_pkg::out_t out_data_o
);

  localparam int TW    = (NumTrees > 1) ? $clog2(NumTrees) : 1;
  localparam int Depth = NumTrees << CodeBits;
  localparam int AW    = $clog2(Depth);
  localparam int EW    = $bits(fpt_pkg::entry_t);

  localparam logic [2:0] ST_CLR = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_LRD = 3'd2;
  localparam logic [2:0] ST_LWT = 3'd3;
  localparam logic [2:0] ST_LST = 3'd4;
  localparam logic [2:0] ST_LDV = 3'd5;

  logic [2:0] state_q, state_d;
  logic       enable_q;

  // clear sweep
  logic [AW-1:0] clr_q;

  // window tracking
  logic [TW-1:0]       tree_q;
  logic [CodeBits-1:0] code_in;
  logic [CodeBits-1:0] cbuf_q [NumTrees];
  logic                in_fire;

  // read stage
  logic v1_q, first1_q, last1_q, act1_q, lab1_q;
  logic [fpt_pkg::SumW-1:0] sum_q, sum_new;

  // decision stage
  logic dec_q, dact_q, dlab_q;
  logic out_free, out_load, learn;
  fpt_pkg::out_t out_q, out_d;
  logic          out_valid_q;

  // learn walk
  logic [TW-1:0]               lt_q;
  logic [AW-1:0]               la_q;
  logic [fpt_pkg::CountW-1:0]  pos_q, neg_q;
  logic [fpt_pkg::SumW-1:0]    cnt_sum;
  logic [fpt_pkg::DsrW-1:0]    divisor;
  fpt_pkg::div_ctl_t           div_ctl;
  fpt_pkg::div_sts_t           div_sts;
  logic [fpt_pkg::DvdW-1:0]    quotient;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  fpt_pkg::entry_t ram_wdata, ram_rdata;
  logic [EW-1:0]   ram_rdata_raw;

  assign code_in    = CodeBits'(in_data_i.fern_code);
  assign in_ready_o = (state_q == ST_RUN) && !dec_q && !(v1_q && last1_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_rdata  = fpt_pkg::entry_t'(ram_rdata_raw);

  assign sum_new  = (first1_q ? '0 : sum_q) + fpt_pkg::SumW'(ram_rdata.post);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_RUN) && dec_q && out_free;
  assign learn    = enable_q && dact_q &&
                    ((dlab_q && (sum_q < fpt_pkg::Half)) ||
                     (!dlab_q && (sum_q > fpt_pkg::Half)));

  always_comb begin
    if (enable_q) begin
      out_d.confidence = sum_q[fpt_pkg::SumW-1] ? 16'hFFFF : sum_q[15:0];
      out_d.passed     = (sum_q >= fpt_pkg::Half);
      out_d.updated    = learn;
    end else begin
      out_d.confidence = '0;
      out_d.passed     = 1'b1;
      out_d.updated    = 1'b0;
    end
  end

  // divisor = 10 * (pos + neg)
  assign cnt_sum = fpt_pkg::SumW'(pos_q) + fpt_pkg::SumW'(neg_q);
  assign divisor = (fpt_pkg::DsrW'(cnt_sum) << 3) + (fpt_pkg::DsrW'(cnt_sum) << 1);
  assign div_ctl.start = (state_q == ST_LST);

  always_comb begin
    ram_raddr = (state_q == ST_RUN) ? AW'({tree_q, code_in}) : AW'({lt_q, cbuf_q[lt_q]});
    ram_we    = 1'b0;
    ram_waddr = la_q;
    ram_wdata = '{post: quotient[fpt_pkg::CountW-1:0], pos: pos_q, neg: neg_q};
    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_LDV: ram_we = div_sts.done;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR: if (clr_q == AW'(Depth - 1)) state_d = ST_RUN;
      ST_RUN: if (out_load && learn) state_d = ST_LRD;
      ST_LRD: state_d = ST_LWT;
      ST_LWT: state_d = ST_LST;
      ST_LST: state_d = ST_LDV;
      ST_LDV: begin
        if (div_sts.done) begin
          state_d = (lt_q == TW'(NumTrees - 1)) ? ST_RUN : ST_LRD;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      enable_q    <= 1'b1;
      clr_q       <= '0;
      tree_q      <= '0;
      v1_q        <= 1'b0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
      lt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) enable_q <= cfg_wdata_i;
      if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
      if (in_fire) begin
        tree_q <= (tree_q == TW'(NumTrees - 1)) ? '0 : tree_q + 1'b1;
      end
      v1_q <= in_fire;
      if (v1_q && last1_q) begin
        dec_q <= 1'b1;
      end else if (out_load) begin
        dec_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        lt_q <= '0;
      end else if (state_q == ST_LDV && div_sts.done) begin
        lt_q <= lt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cbuf_q[tree_q] <= code_in;
      first1_q       <= (tree_q == '0);
      last1_q        <= (tree_q == TW'(NumTrees - 1));
      act1_q         <= in_data_i.action;
      lab1_q         <= in_data_i.label_positive;
    end
    if (v1_q) begin
      sum_q <= sum_new;
      if (last1_q) begin
        dact_q <= act1_q;
        dlab_q <= lab1_q;
      end
    end
    if (out_load) out_q <= out_d;
    if (state_q == ST_LRD) la_q <= ram_raddr;
    if (state_q == ST_LWT) begin
      if (dlab_q) begin
        pos_q <= (ram_rdata.pos == fpt_pkg::CountMax) ? ram_rdata.pos : ram_rdata.pos + 1'b1;
        neg_q <= ram_rdata.neg;
      end else begin
        pos_q <= ram_rdata.pos;
        neg_q <= (ram_rdata.neg == fpt_pkg::CountMax) ? ram_rdata.neg : ram_rdata.neg + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  fpt_ram #(
    .Width(EW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(EW'(ram_wdata)),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  fpt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_ctl),
    .dividend_i({pos_q, 16'h0000}),
    .divisor_i (divisor),
    .sts_o     (div_sts),
    .quotient_o(quotient)
  );

  `FPT_ASSERT_NOW(a_no_write_on_accept, ram_we, !in_fire)
  `FPT_ASSERT_NEXT(a_update_starts_walk, out_load && out_d.updated, state_q == ST_LRD)
  `FPT_ASSERT_NOW(a_div_start_idle, div_ctl.start, !div_sts.busy)

endmodule

// ----- tb/fern_posterior_table_top_tb.sv -----
module fern_posterior_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTrees    = fpt_pkg::NumTreesDef;
  localparam int CBits     = fpt_pkg::CodeBitsDef;
  localparam int Entries   = NTrees << CBits;
  // Long enough for a full learn walk; leave slack on top.
  localparam int LearnWait = NTrees * 40 + 50;
  // Clearing pass after reset, plus every window learning at its slowest.
  localparam longint CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  fpt_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  fpt_pkg::out_t out_data_o;

  fern_posterior_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the fern table and window state.
  bit [15:0] post_mem [Entries];
  bit [15:0] pos_mem  [Entries];
  bit [15:0] neg_mem  [Entries];
  bit [CBits-1:0] win_codes [NTrees];
  int        tree_idx = 0;
  bit [16:0] run_sum = '0;
  bit        enabled = 1'b1;

  fpt_pkg::in_t  pending_beats [$];
  fpt_pkg::out_t expected_windows [$];
  int   errors = 0;
  bit   no_idle = 1'b0;
  bit   stim_done = 1'b0;
  longint cycles = 0;

  function automatic int slot(int tree, bit [CBits-1:0] code);
    return tree * (1 << CBits) + int'(code);
  endfunction

  // Bump one count (saturating) and refresh the posterior.
  function automatic void train_entry(int idx, bit positive);
    longint unsigned p, n;
    if (positive) begin
      if (pos_mem[idx] != fpt_pkg::CountMax) pos_mem[idx]++;
    end else begin
      if (neg_mem[idx] != fpt_pkg::CountMax) neg_mem[idx]++;
    end
    p = pos_mem[idx];
    n = neg_mem[idx];
    post_mem[idx] = (p + n == 0) ? 16'd0 : 16'((p * 65536) / (10 * (p + n)));
  endfunction

  // Accumulate one beat; on the last tree decide, maybe learn, queue the result.
  function automatic void classify_beat(fpt_pkg::in_t b);
    bit [CBits-1:0] code;
    bit [16:0]      sum;
    bit             learn;
    fpt_pkg::out_t  r;
    code = b.fern_code[CBits-1:0];
    win_codes[tree_idx] = code;
    sum = ((tree_idx == 0) ? 17'd0 : run_sum) + 17'(post_mem[slot(tree_idx, code)]);
    if (tree_idx + 1 < NTrees) begin
      tree_idx++;
      run_sum = sum;
      return;
    end
    tree_idx = 0;
    run_sum = '0;
    if (!enabled) begin
      r.confidence = '0;
      r.passed = 1'b1;
      r.updated = 1'b0;
    end else begin
      learn = b.action && ((b.label_positive && sum < fpt_pkg::Half) ||
                           (!b.label_positive && sum > fpt_pkg::Half));
      if (learn)
        for (int t = 0; t < NTrees; t++) train_entry(slot(t, win_codes[t]), b.label_positive);
      r.confidence = (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
      r.passed = (sum >= fpt_pkg::Half);
      r.updated = learn;
    end
    expected_windows.push_back(r);
  endfunction

  // Driver: hold the beat until taken; random idle bursts between beats unless no_idle.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) classify_beat(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_beats.pop_front();
          if (!no_idle && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure bursts, compare each result beat in order.
  int out_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          fpt_pkg::out_t e;
          e = expected_windows.pop_front();
          if (out_data_o.confidence !== e.confidence) begin
            $display("%0t: confidence exp %0d got %0d", $time, e.confidence,
                     out_data_o.confidence);
            errors++;
          end
          if (out_data_o.passed !== e.passed) begin
            $display("%0t: passed exp %0b got %0b", $time, e.passed, out_data_o.passed);
            errors++;
          end
          if (out_data_o.updated !== e.updated) begin
            $display("%0t: updated exp %0b got %0b", $time, e.updated, out_data_o.updated);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fern_posterior_table_top_tb: done, errors");
      $finish;
    end
  end

  // Queue one full window; every tree gets the same action/label here.
  task automatic push_window(bit [CBits-1:0] code, bit act, bit lbl);
    fpt_pkg::in_t b;
    for (int t = 0; t < NTrees; t++) begin
      b.action = act;
      b.fern_code = code;
      b.label_positive = lbl;
      pending_beats.push_back(b);
    end
  endtask

  // Random window: codes mostly from a tiny pool so entries get trained
  // repeatedly and confidence swings across one half; some full-range codes.
  task automatic push_random_window();
    fpt_pkg::in_t b;
    int  r;
    for (int t = 0; t < NTrees; t++) begin
      r = $urandom_range(0, 9);
      b.fern_code = (r < 7) ? 13'($urandom_range(0, 3)) :
                    (r == 7) ? 13'h1FFF : 13'($urandom_range(0, 8191));
      b.action = ($urandom_range(0, 3) != 0);
      b.label_positive = 1'($urandom_range(0, 1));
      pending_beats.push_back(b);
    end
  endtask

  // Drain everything, let a possible learn walk finish, then write the register.
  task automatic set_enable(bit v);
    wait (pending_beats.size() == 0 && !in_valid_i && expected_windows.size() == 0);
    repeat (LearnWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    enabled = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, learn positive on the top code, then a negative
    // learn pulling it back, then a plain classify of the result.
    push_window('0, 1'b0, 1'b1);
    push_window(13'h1FFF, 1'b1, 1'b1);
    push_window(13'h1FFF, 1'b1, 1'b0);
    push_window(13'h1FFF, 1'b0, 1'b0);

    set_enable(1'b0);
    // Disabled: learn requests are ignored, every window passes.
    push_window(13'h1FFF, 1'b1, 1'b1);
    for (int w = 0; w < 20; w++) push_random_window();

    set_enable(1'b1);
    for (int w = 0; w < 70; w++) push_random_window();

    set_enable(1'b0);
    for (int w = 0; w < 15; w++) push_random_window();

    set_enable(1'b1);
    for (int w = 0; w < 50; w++) push_random_window();
    wait (pending_beats.size() == 0);
    no_idle = 1'b1;
    for (int w = 0; w < 30; w++) push_random_window();

    wait (pending_beats.size() == 0 && !in_valid_i && expected_windows.size() == 0);
    repeat (LearnWait) @(posedge clk_i);
    if (errors == 0 && expected_windows.size() == 0) begin
      $display("fern_posterior_table_top_tb: done, clean");
    end else begin
      $display("fern_posterior_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fpt_pkg.sv
rtl/fpt_ram.sv
rtl/fpt_div.sv
rtl/fern_posterior_table_top.sv
tb/fern_posterior_table_top_tb.sv
